[rtl/core/six_axis_moving_average_deadband_macros.svh]
// ----------------------------------------------------------------------------
// Six-axis moving average with deadband: assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef SIX_AXIS_MOVING_AVERAGE_DEADBAND_MACROS_SVH
`define SIX_AXIS_MOVING_AVERAGE_DEADBAND_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SMAD_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("six_axis_moving_average_deadband: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define SMAD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("six_axis_moving_average_deadband: next-cycle check failed");

`endif

[rtl/core/smad_pkg.sv]
// ----------------------------------------------------------------------------
// smad_pkg
// Sizes, constants and controller/datapath interface types of the
// six-axis moving average with deadband.
// ----------------------------------------------------------------------------
`default_nettype none

package smad_pkg;

  // Window length and channel layout.
  localparam int WINDOW   = 25;
  localparam int CHANNELS = 6;
  localparam int DATA_W   = 32;
  localparam int ROW_W    = DATA_W * CHANNELS;

  // A sum of WINDOW samples grows by at most $clog2(WINDOW) bits.
  localparam int SUM_W  = DATA_W + $clog2(WINDOW);
  localparam int CNT_W  = $clog2(WINDOW + 1);
  localparam int SLOT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int STEP_W = $clog2(SUM_W);

  // Deadband register.
  localparam int BAND_W = 31;
  localparam logic [BAND_W-1:0] DEAD_BAND_RESET = 31'd131072;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;   // latch the item and read the oldest ring entry
    logic sub_old;   // remove the oldest sample from the sums when full
    logic add_new;   // add the new sample, write the ring, advance pointers
    logic div_init;  // load the divider lanes with the sum magnitudes
    logic div_step;  // one quotient bit in every lane
    logic load_out;  // apply the deadband and load the output register
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic div_last;  // the current division step is the final one
  } sts_t;

endpackage

`default_nettype wire

[rtl/core/smad_ctrl.sv]
// ----------------------------------------------------------------------------
// smad_ctrl
// Sequencer for one item: capture, sum update, bit-serial divide and
// output load. Also owns the output valid flag.
// ----------------------------------------------------------------------------
`default_nettype none

module smad_ctrl
  import smad_pkg::*;
(
  input  wire  clk,
  input  wire  rst,
  input  wire  in_valid,
  output logic in_ready,
  output logic out_valid,
  input  wire  out_ready,
  output cmd_t cmd,
  input  sts_t sts
);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_SUB   = 6'b000010,
    S_ADD   = 6'b000100,
    S_DINIT = 6'b001000,
    S_DIV   = 6'b010000,
    S_FIN   = 6'b100000
  } state_t;

  state_t state;
  state_t state_next;
  logic   out_free;

  // The output register can take a new result when empty or being drained.
  // No item is taken while reset is held.
  assign out_free = !out_valid || out_ready;
  assign in_ready = (state == S_IDLE) && !rst;

  // Command decode.
  always_comb begin
    cmd          = '0;
    cmd.capture  = in_ready && in_valid;
    cmd.sub_old  = (state == S_SUB);
    cmd.add_new  = (state == S_ADD);
    cmd.div_init = (state == S_DINIT);
    cmd.div_step = (state == S_DIV);
    cmd.load_out = (state == S_FIN) && out_free;
  end

  // Next-state logic.
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) state_next = S_SUB;
      end
      S_SUB:   state_next = S_ADD;
      S_ADD:   state_next = S_DINIT;
      S_DINIT: state_next = S_DIV;
      S_DIV: begin
        if (sts.div_last) state_next = S_FIN;
      end
      S_FIN: begin
        if (out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // State and output valid registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

[rtl/core/smad_dp.sv]
// ----------------------------------------------------------------------------
// smad_dp
// Datapath: sample ring memory, running channel sums, six bit-serial
// divider lanes, deadband and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module smad_dp
  import smad_pkg::*;
(
  input  wire                     clk,
  input  wire                     rst,
  input  cmd_t                    cmd,
  output sts_t                    sts,
  input  wire                     cfg_valid,
  input  wire        [BAND_W-1:0] cfg_data,
  input  wire        [DATA_W-1:0] stamp_tag,
  input  wire signed [DATA_W-1:0] force_x,
  input  wire signed [DATA_W-1:0] force_y,
  input  wire signed [DATA_W-1:0] force_z,
  input  wire signed [DATA_W-1:0] torque_x,
  input  wire signed [DATA_W-1:0] torque_y,
  input  wire signed [DATA_W-1:0] torque_z,
  output logic       [DATA_W-1:0] stamp_out,
  output logic signed [DATA_W-1:0] avg_force_x,
  output logic signed [DATA_W-1:0] avg_force_y,
  output logic signed [DATA_W-1:0] avg_force_z,
  output logic signed [DATA_W-1:0] avg_torque_x,
  output logic signed [DATA_W-1:0] avg_torque_y,
  output logic signed [DATA_W-1:0] avg_torque_z
);

  logic signed [DATA_W-1:0] in_vec [CHANNELS];
  logic signed [DATA_W-1:0] samp   [CHANNELS];
  logic signed [DATA_W-1:0] avg    [CHANNELS];
  logic        [DATA_W-1:0] tag;

  logic [ROW_W-1:0] ring [WINDOW];
  logic [ROW_W-1:0] rd_row;
  logic [ROW_W-1:0] wr_row;

  logic signed [SUM_W-1:0] sums [CHANNELS];
  logic [CNT_W-1:0]  fill_count;
  logic [SLOT_W-1:0] slot;
  logic              full;
  logic [BAND_W-1:0] band;

  logic [SUM_W-1:0]  dq     [CHANNELS];
  logic [CNT_W-1:0]  rem    [CHANNELS];
  logic [CNT_W-1:0]  rem_nx [CHANNELS];
  logic [CNT_W:0]    rem_sh [CHANNELS];
  logic              ge     [CHANNELS];
  logic              neg    [CHANNELS];
  logic [DATA_W-1:0] quo    [CHANNELS];
  logic [STEP_W-1:0] step_cnt;

  assign in_vec[0] = force_x;
  assign in_vec[1] = force_y;
  assign in_vec[2] = force_z;
  assign in_vec[3] = torque_x;
  assign in_vec[4] = torque_y;
  assign in_vec[5] = torque_z;

  assign avg_force_x  = avg[0];
  assign avg_force_y  = avg[1];
  assign avg_force_z  = avg[2];
  assign avg_torque_x = avg[3];
  assign avg_torque_y = avg[4];
  assign avg_torque_z = avg[5];

  assign full         = (fill_count == CNT_W'(WINDOW));
  assign sts.div_last = (step_cnt == STEP_W'(SUM_W - 1));

  // Pack the captured sample into one ring row.
  always_comb begin
    wr_row = '0;
    for (int c = 0; c < CHANNELS; c++) begin
      wr_row[c*DATA_W +: DATA_W] = samp[c];
    end
  end

  // Restoring division step per lane; the divisor is the sample count.
  always_comb begin
    for (int c = 0; c < CHANNELS; c++) begin
      rem_sh[c] = {rem[c], dq[c][SUM_W-1]};
      ge[c]     = (rem_sh[c] >= {1'b0, fill_count});
      rem_nx[c] = ge[c] ? CNT_W'(rem_sh[c] - {1'b0, fill_count}) : CNT_W'(rem_sh[c]);
      quo[c]    = dq[c][DATA_W-1:0];
    end
  end

  // Deadband register.
  always_ff @(posedge clk) begin
    if (rst) begin
      band <= DEAD_BAND_RESET;
    end else if (cfg_valid) begin
      band <= cfg_data;
    end
  end

  // Ring memory with a registered read of the slot about to be replaced.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      rd_row <= ring[slot];
    end
    if (cmd.add_new) begin
      ring[slot] <= wr_row;
    end
  end

  // Captured item.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      tag <= stamp_tag;
      for (int c = 0; c < CHANNELS; c++) begin
        samp[c] <= in_vec[c];
      end
    end
  end

  // Running sums, fill count and write slot.
  always_ff @(posedge clk) begin
    if (rst) begin
      fill_count <= '0;
      slot       <= '0;
      for (int c = 0; c < CHANNELS; c++) begin
        sums[c] <= '0;
      end
    end else begin
      if (cmd.sub_old && full) begin
        for (int c = 0; c < CHANNELS; c++) begin
          sums[c] <= sums[c] - SUM_W'($signed(rd_row[c*DATA_W +: DATA_W]));
        end
      end
      if (cmd.add_new) begin
        for (int c = 0; c < CHANNELS; c++) begin
          sums[c] <= sums[c] + SUM_W'(samp[c]);
        end
        if (!full) begin
          fill_count <= fill_count + 1'b1;
        end
        slot <= (slot == SLOT_W'(WINDOW - 1)) ? '0 : slot + 1'b1;
      end
    end
  end

  // Divider lanes: magnitude in, one quotient bit shifted in per step.
  always_ff @(posedge clk) begin
    if (rst) begin
      step_cnt <= '0;
    end else if (cmd.div_init) begin
      step_cnt <= '0;
    end else if (cmd.div_step) begin
      step_cnt <= step_cnt + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_init) begin
      for (int c = 0; c < CHANNELS; c++) begin
        neg[c] <= sums[c][SUM_W-1];
        dq[c]  <= sums[c][SUM_W-1] ? SUM_W'(-sums[c]) : SUM_W'(sums[c]);
        rem[c] <= '0;
      end
    end else if (cmd.div_step) begin
      for (int c = 0; c < CHANNELS; c++) begin
        dq[c]  <= {dq[c][SUM_W-2:0], ge[c]};
        rem[c] <= rem_nx[c];
      end
    end
  end

  // Deadband on the truncated magnitude, sign restored, into the output register.
  // The tag is copied here too, so a pending result holds while the next item runs.
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      stamp_out <= tag;
      for (int c = 0; c < CHANNELS; c++) begin
        if (quo[c] < DATA_W'(band)) begin
          avg[c] <= '0;
        end else begin
          avg[c] <= neg[c] ? -quo[c] : quo[c];
        end
      end
    end
  end

endmodule

`default_nettype wire

[rtl/core/six_axis_moving_average_deadband.sv]
// ----------------------------------------------------------------------------
// six_axis_moving_average_deadband
// Windowed mean of six force/torque channels with a programmable deadband.
// ----------------------------------------------------------------------------
// Each accepted item is one six-axis sample with a tag; the block keeps the
// last 25 samples and returns one result per item: the tag and the six
// channel means (truncated toward zero, zeroed when strictly inside the
// deadband). While fewer than 25 samples are held, the mean is over those
// held. One item is processed at a time: after acceptance it goes through
// the removal of the oldest sample when full, the addition of the new one,
// the divider load, the bit-serial division and the output load, and no
// new item is taken before that load. The pace is set by the six bit-serial
// divider lanes, which produce one quotient bit per cycle over the 37-bit
// channel sums. A finished result waits in an output register, so the next
// item is accepted while it is still pending. The deadband register may be
// written at any time the block is idle and resets to 2.0 in Q15.16.
`default_nettype none

module six_axis_moving_average_deadband
  import smad_pkg::*;
(
  input  wire                      clk,
  input  wire                      rst,
  input  wire                      cfg_valid,
  output logic                     cfg_ready,
  input  wire        [BAND_W-1:0]  cfg_data,
  input  wire                      in_valid,
  output logic                     in_ready,
  input  wire        [DATA_W-1:0]  stamp_tag,
  input  wire signed [DATA_W-1:0]  force_x,
  input  wire signed [DATA_W-1:0]  force_y,
  input  wire signed [DATA_W-1:0]  force_z,
  input  wire signed [DATA_W-1:0]  torque_x,
  input  wire signed [DATA_W-1:0]  torque_y,
  input  wire signed [DATA_W-1:0]  torque_z,
  output logic                     out_valid,
  input  wire                      out_ready,
  output logic       [DATA_W-1:0]  stamp_out,
  output logic signed [DATA_W-1:0] avg_force_x,
  output logic signed [DATA_W-1:0] avg_force_y,
  output logic signed [DATA_W-1:0] avg_force_z,
  output logic signed [DATA_W-1:0] avg_torque_x,
  output logic signed [DATA_W-1:0] avg_torque_y,
  output logic signed [DATA_W-1:0] avg_torque_z
);

  cmd_t cmd;
  sts_t sts;

  // The deadband register takes a write in any cycle outside reset.
  assign cfg_ready = !rst;

  smad_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  smad_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .sts          (sts),
    .cfg_valid    (cfg_valid),
    .cfg_data     (cfg_data),
    .stamp_tag    (stamp_tag),
    .force_x      (force_x),
    .force_y      (force_y),
    .force_z      (force_z),
    .torque_x     (torque_x),
    .torque_y     (torque_y),
    .torque_z     (torque_z),
    .stamp_out    (stamp_out),
    .avg_force_x  (avg_force_x),
    .avg_force_y  (avg_force_y),
    .avg_force_z  (avg_force_z),
    .avg_torque_x (avg_torque_x),
    .avg_torque_y (avg_torque_y),
    .avg_torque_z (avg_torque_z)
  );

endmodule

`default_nettype wire

[rtl/core/smad_checker.sv]
// ----------------------------------------------------------------------------
// smad_checker
// Port-level checks of the six-axis moving average, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "six_axis_moving_average_deadband_macros.svh"

module smad_checker
  import smad_pkg::*;
(
  input wire              clk,
  input wire              rst,
  input wire              cfg_ready,
  input wire              in_valid,
  input wire              in_ready,
  input wire              out_valid,
  input wire              out_ready,
  input wire [DATA_W-1:0] stamp_out,
  input wire [DATA_W-1:0] avg_force_x,
  input wire [DATA_W-1:0] avg_torque_z
);

  // A stalled result stays valid and unchanged.
  `SMAD_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(stamp_out) && $stable(avg_force_x) && $stable(avg_torque_z))

  // Once an item is taken the block is busy with it.
  `SMAD_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready)

  // A new result never shows up the cycle after an item is taken.
  `SMAD_ASSERT_NEXT(a_no_instant_result, in_valid && in_ready, !$rose(out_valid))

  // A new result is loaded only at the end of an item's work.
  `SMAD_ASSERT_SAME(a_result_from_work, $rose(out_valid), !$past(in_ready) && cfg_ready)

endmodule

bind six_axis_moving_average_deadband smad_checker u_smad_checker (.*);

`default_nettype wire

[dv/tb_six_axis_moving_average_deadband.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_six_axis_moving_average_deadband
// Self-checking bench for the six-axis windowed mean with deadband. A
// scoreboard class tracks its own ring of samples, running sums and deadband,
// and predicts each result from the items accepted on the input channel.
// Results are compared field by field in order. Stimulus is a short directed
// set followed by random bursts: full-range noise, small values, runs of the
// extremes, and runs that settle near the deadband edges. The bursts run under
// several deadband settings; the first four phases stall both sides at random.
// ----------------------------------------------------------------------------
module tb_six_axis_moving_average_deadband;
  import smad_pkg::*;

  localparam int     STALL_LIMIT     = 2000;
  localparam int     SETTLE_CYCLES   = SUM_W + 5 + 8;
  localparam int     ITEMS_PER_PHASE = 150;
  localparam int     PHASES          = 6;
  localparam longint Q_MAX           = 64'sd2147483647;
  localparam longint Q_MIN           = -64'sd2147483648;

  // One sample or one result: the tag and six channels, force x first.
  typedef struct packed {
    logic [DATA_W-1:0]               tag;
    logic [CHANNELS-1:0][DATA_W-1:0] axis;
  } ft_sample_t;

  // Shapes of the random bursts.
  typedef enum int {MIX_FULL, MIX_NEAR_BAND, MIX_EXTREME, MIX_SMALL} mix_t;

  // Tracks the window and the deadband, and holds the means still to come.
  class windowed_mean_tracker;
    int                ring [WINDOW][CHANNELS];
    longint            sums [CHANNELS];
    int                held;
    int                next_slot;
    logic [BAND_W-1:0] band;
    ft_sample_t        expected_means [$];
    int                mismatches;
    int                results_seen;

    function new();
      foreach (sums[c]) sums[c] = 0;
      held         = 0;
      next_slot    = 0;
      band         = DEAD_BAND_RESET;
      mismatches   = 0;
      results_seen = 0;
    endfunction

    function int pending();
      return expected_means.size();
    endfunction

    // Update the window with an accepted sample and queue the mean it causes.
    function void note_sample(ft_sample_t s);
      ft_sample_t mean;
      longint     q;
      longint     th;
      bit         full;
      full = (held >= WINDOW);
      for (int c = 0; c < CHANNELS; c++) begin
        // Once the ring is full, the slot being overwritten holds the oldest sample.
        if (full) sums[c] -= longint'(ring[next_slot][c]);
        sums[c] += longint'($signed(s.axis[c]));
        ring[next_slot][c] = $signed(s.axis[c]);
      end
      if (!full) held++;
      next_slot = (next_slot + 1 >= WINDOW) ? 0 : next_slot + 1;

      // Truncating division, then zero anything strictly inside the band.
      mean.tag = s.tag;
      th = longint'(band);
      for (int c = 0; c < CHANNELS; c++) begin
        q = sums[c] / longint'(held);
        if (q < th && q > -th) q = 0;
        mean.axis[c] = q[DATA_W-1:0];
      end
      expected_means.push_back(mean);
    endfunction

    task report(string what);
      mismatches++;
      $display("MISMATCH at %0t ns: %s", $time, what);
    endtask

    // Compare one result with the oldest mean still expected.
    task check_result(ft_sample_t got);
      ft_sample_t want;
      results_seen++;
      if (expected_means.size() == 0) begin
        report($sformatf("result with tag %h arrived with nothing expected", got.tag));
        return;
      end
      want = expected_means.pop_front();
      if (got.tag !== want.tag)
        report($sformatf("stamp_out: got %h, expected %h", got.tag, want.tag));
      // Channel order: force x, y, z, then torque x, y, z.
      for (int c = 0; c < CHANNELS; c++) begin
        if (got.axis[c] !== want.axis[c])
          report($sformatf("channel %0d of tag %h: got %h, expected %h",
                           c, want.tag, got.axis[c], want.axis[c]));
      end
    endtask
  endclass

  logic                     clk          = 1'b0;
  logic                     rst          = 1'b1;
  logic                     cfg_valid    = 1'b0;
  logic                     cfg_ready;
  logic        [BAND_W-1:0] cfg_data     = '0;
  logic                     in_valid     = 1'b0;
  logic                     in_ready;
  logic        [DATA_W-1:0] stamp_tag    = '0;
  logic signed [DATA_W-1:0] force_x      = '0;
  logic signed [DATA_W-1:0] force_y      = '0;
  logic signed [DATA_W-1:0] force_z      = '0;
  logic signed [DATA_W-1:0] torque_x     = '0;
  logic signed [DATA_W-1:0] torque_y     = '0;
  logic signed [DATA_W-1:0] torque_z     = '0;
  logic                     out_valid;
  logic                     out_ready    = 1'b0;
  logic        [DATA_W-1:0] stamp_out;
  logic signed [DATA_W-1:0] avg_force_x;
  logic signed [DATA_W-1:0] avg_force_y;
  logic signed [DATA_W-1:0] avg_force_z;
  logic signed [DATA_W-1:0] avg_torque_x;
  logic signed [DATA_W-1:0] avg_torque_y;
  logic signed [DATA_W-1:0] avg_torque_z;

  windowed_mean_tracker tracker = new();
  int send_idle_pct = 21;
  int recv_idle_pct = 59;
  int samples_taken = 0;
  int band_settings = 0;
  int quiet_cycles  = 0;

  six_axis_moving_average_deadband dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .stamp_tag    (stamp_tag),
    .force_x      (force_x),
    .force_y      (force_y),
    .force_z      (force_z),
    .torque_x     (torque_x),
    .torque_y     (torque_y),
    .torque_z     (torque_z),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .stamp_out    (stamp_out),
    .avg_force_x  (avg_force_x),
    .avg_force_y  (avg_force_y),
    .avg_force_z  (avg_force_z),
    .avg_torque_x (avg_torque_x),
    .avg_torque_y (avg_torque_y),
    .avg_torque_z (avg_torque_z)
  );

  // 100 MHz clock.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // The result side stalls at random.
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Watch both channels at each edge, and end the run if nothing moves for too long.
  always @(posedge clk) begin : port_watch
    ft_sample_t seen;
    if (!rst) begin
      if (in_valid && in_ready) begin
        seen.tag     = stamp_tag;
        seen.axis[0] = force_x;
        seen.axis[1] = force_y;
        seen.axis[2] = force_z;
        seen.axis[3] = torque_x;
        seen.axis[4] = torque_y;
        seen.axis[5] = torque_z;
        tracker.note_sample(seen);
        samples_taken++;
      end
      if (out_valid && out_ready) begin
        seen.tag     = stamp_out;
        seen.axis[0] = avg_force_x;
        seen.axis[1] = avg_force_y;
        seen.axis[2] = avg_force_z;
        seen.axis[3] = avg_torque_x;
        seen.axis[4] = avg_torque_y;
        seen.axis[5] = avg_torque_z;
        tracker.check_result(seen);
      end
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("Timeout: no item moved for %0d cycles, %0d results outstanding",
                 STALL_LIMIT, tracker.pending());
        $display("FAILED: results differ");
        $finish;
      end
    end
  end

  // Wait on the clock until every expected result has come back.
  task automatic wait_drain();
    do @(posedge clk); while (tracker.pending() != 0);
  endtask

  // Write the deadband register; only called while the block is idle.
  task automatic write_dead_band(input logic [BAND_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid    <= 1'b0;
    tracker.band  = value;
    band_settings++;
  endtask

  // Present one sample, with a random gap first, and hold it until accepted.
  // Valid stays high afterwards so that back-to-back items need no gap.
  task automatic send_sample(input ft_sample_t s);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid  <= 1'b1;
    stamp_tag <= s.tag;
    force_x   <= s.axis[0];
    force_y   <= s.axis[1];
    force_z   <= s.axis[2];
    torque_x  <= s.axis[3];
    torque_y  <= s.axis[4];
    torque_z  <= s.axis[5];
    do @(posedge clk); while (!in_ready);
  endtask

  // Deadband edges at one held sample, full-scale values, sign patterns.
  task automatic run_directed();
    ft_sample_t        s;
    logic [DATA_W-1:0] band_edge;
    band_edge = DATA_W'(DEAD_BAND_RESET);
    for (int k = 0; k < 16; k++) begin
      s.tag = $urandom();
      case (k)
        0: begin
          // With one sample held the mean is the sample itself.
          s.tag     = '0;
          s.axis[0] = band_edge;
          s.axis[1] = -band_edge;
          s.axis[2] = band_edge - 1;
          s.axis[3] = 1 - band_edge;
          s.axis[4] = 1;
          s.axis[5] = '1;
        end
        1: begin
          s.tag  = '1;
          s.axis = {CHANNELS{32'h7FFF_FFFF}};
        end
        2: begin
          // The last two samples sum to -1; over three held samples every mean is in the deadband.
          s.tag  = 32'h8000_0000;
          s.axis = {CHANNELS{32'h8000_0000}};
        end
        3: begin
          s.tag  = 32'h7FFF_FFFF;
          s.axis = '0;
        end
        4: begin
          s.tag  = 32'hAAAA_AAAA;
          s.axis = {CHANNELS{32'hAAAA_AAAA}};
        end
        5: begin
          s.tag  = 32'h5555_5555;
          s.axis = {CHANNELS{32'h5555_5555}};
        end
        default: begin
          for (int c = 0; c < CHANNELS; c++) s.axis[c] = $urandom();
        end
      endcase
      send_sample(s);
    end
  endtask

  // One burst of random samples of a given shape.
  task automatic send_burst(input mix_t kind, input int len);
    longint     base [CHANNELS];
    longint     v;
    longint     th;
    ft_sample_t s;
    th = longint'(tracker.band);
    for (int c = 0; c < CHANNELS; c++) begin
      if (kind == MIX_EXTREME)
        base[c] = $urandom_range(1) ? Q_MAX : Q_MIN;
      else
        base[c] = $urandom_range(1) ? th : -th;
    end
    for (int i = 0; i < len; i++) begin
      s.tag = $urandom();
      for (int c = 0; c < CHANNELS; c++) begin
        case (kind)
          MIX_FULL:    s.axis[c] = $urandom();
          MIX_SMALL:   s.axis[c] = $urandom_range(0, 32'h0008_0000) - 32'h0004_0000;
          MIX_EXTREME: s.axis[c] = base[c][DATA_W-1:0];
          default: begin
            // Jitter around a band edge so the settled mean lands on or next to it.
            v = base[c] + longint'($urandom_range(0, 6)) - 3;
            if (v > Q_MAX) v = Q_MAX;
            if (v < Q_MIN) v = Q_MIN;
            s.axis[c] = v[DATA_W-1:0];
          end
        endcase
      end
      send_sample(s);
    end
  endtask

  initial begin : stimulus
    int   sent;
    int   len;
    mix_t kind;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Directed items run with the deadband at its reset value.
    run_directed();

    for (int p = 0; p < PHASES; p++) begin
      in_valid <= 1'b0;
      wait_drain();
      case (p)
        0:       write_dead_band('0);
        1:       write_dead_band(BAND_W'($urandom_range(1, 32'h0010_0000)));
        2:       write_dead_band('1);
        3:       write_dead_band(BAND_W'(1));
        4:       write_dead_band(BAND_W'($urandom()));
        default: write_dead_band(DEAD_BAND_RESET);
      endcase

      // Receiver-heavy stalls, then sender-heavy, then none.
      case (p / 2)
        0: begin
          send_idle_pct = 21;
          recv_idle_pct = 59;
        end
        1: begin
          send_idle_pct = 59;
          recv_idle_pct = 21;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase

      sent = 0;
      while (sent < ITEMS_PER_PHASE) begin
        kind = mix_t'($urandom_range(3));
        if (kind == MIX_EXTREME || kind == MIX_NEAR_BAND)
          len = $urandom_range(25, 35);
        else
          len = $urandom_range(1, 20);
        send_burst(kind, len);
        sent += len;
        // Now and then hold off until the block has emptied.
        if ($urandom_range(7) == 0) begin
          in_valid <= 1'b0;
          wait_drain();
        end
      end
    end
    in_valid <= 1'b0;

    wait_drain();
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Run covered %0d samples and %0d results over %0d deadband writes,",
             samples_taken, tracker.results_seen, band_settings);
    $display("including window fill and wrap, full-scale runs and deadband edges.");
    if (tracker.mismatches == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end

endmodule

[filelist.f]
+incdir+rtl/core
rtl/core/smad_pkg.sv
rtl/core/smad_ctrl.sv
rtl/core/smad_dp.sv
rtl/core/six_axis_moving_average_deadband.sv
rtl/core/smad_checker.sv
dv/tb_six_axis_moving_average_deadband.sv
